/* rtl/edr_pkg.sv */
// Shared types, constants and helpers for the edit distance row engine.
// No dependencies; imported by edr_cell and edit_distance_row_engine.
`timescale 1ns / 1ps
`default_nettype none

package edr_pkg;

  localparam int DIST_W      = 16;
  localparam int CHAR_W      = 8;
  localparam int OP_W        = 2;
  localparam int MAX_LEN_DEF = 64;

  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_FEED   = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // One step of the row wavefront as it moves from a cell to its neighbor.
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] diag;
  } wave_t;

  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
    sat_inc = (v == DIST_MAX) ? v : v + DIST_W'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/edr_cell.sv */
// One column of the DP row: holds a reference character and its row entry.
// Depends on edr_pkg for the wave type and saturating increment.
`timescale 1ns / 1ps
`default_nettype none

module edr_cell
  import edr_pkg::*;
#(
  parameter int CELL_IDX = 1,
  parameter int LEN_W    = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              init,
  input  wire logic              wr_en,
  input  wire logic [LEN_W-1:0]  wr_idx,
  input  wire logic [CHAR_W-1:0] wr_ch,
  input  wire logic [CHAR_W-1:0] ch,
  input  wire logic [LEN_W-1:0]  len,
  input  wire wave_t             wave_in,
  output wave_t                  wave_out
);

  localparam logic [LEN_W-1:0]  IDX      = LEN_W'(CELL_IDX);
  localparam logic [DIST_W-1:0] INIT_VAL = DIST_W'(CELL_IDX);

  logic [CHAR_W-1:0] ref_ch_r;
  logic [DIST_W-1:0] dp_r;
  logic              wave_vld_r;
  logic [DIST_W-1:0] wave_left_r;
  logic [DIST_W-1:0] wave_diag_r;

  logic              active;
  logic [DIST_W-1:0] up_c;
  logic [DIST_W-1:0] left_c;
  logic [DIST_W-1:0] dg_c;
  logic [DIST_W-1:0] min_c;

  always_comb begin
    active = (IDX <= len);
    up_c   = sat_inc(dp_r);
    left_c = sat_inc(wave_in.left);
    dg_c   = (ch != ref_ch_r) ? sat_inc(wave_in.diag) : wave_in.diag;
    min_c  = up_c;
    if (left_c < min_c) begin
      min_c = left_c;
    end
    if (dg_c < min_c) begin
      min_c = dg_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r       <= INIT_VAL;
      wave_vld_r <= 1'b0;
    end else begin
      wave_vld_r <= wave_in.valid;
      if (init) begin
        dp_r <= INIT_VAL;
      end else if (wave_in.valid && active) begin
        dp_r <= min_c;
      end
    end
  end

  // Cells past the reference length hand the last computed entry on unchanged,
  // so the chain end always carries the entry at the reference length.
  always_ff @(posedge clk) begin
    wave_left_r <= active ? min_c : wave_in.left;
    wave_diag_r <= dp_r;
    if (wr_en && (wr_idx == IDX)) begin
      ref_ch_r <= wr_ch;
    end
  end

  assign wave_out.valid = wave_vld_r;
  assign wave_out.left  = wave_left_r;
  assign wave_out.diag  = wave_diag_r;

endmodule

`default_nettype wire

/* rtl/edit_distance_row_engine.sv */
// Top level of the edit distance row engine: item decode, row entry zero,
// output register and the chain of edr_cell columns. Depends on edr_pkg.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    in_op[1:0], in_ch[7:0]
//   out_      output     out_valid / out_ready  out_distance[15:0], out_status
//
// Start, append and unused codes answer in the cycle after acceptance.
// A feed answers once the row update has run as a wavefront through the chain
// of MAX_LEN cells, one cell per cycle, and reached the output register.
// Reset puts entry j of the row at j directly; no clearing pass.
// in_ready is low while a feed is in the chain, and while a result word waits
// on out_ready; one item is worked on at a time.
`timescale 1ns / 1ps
`default_nettype none

module edit_distance_row_engine
  import edr_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [CHAR_W-1:0] in_ch,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DIST_W-1:0]      out_distance,
  output logic                   out_status
);

  localparam int               LEN_W   = $clog2(MAX_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

  logic              busy_r;
  logic              fed_r;
  logic [LEN_W-1:0]  len_r;
  logic [DIST_W-1:0] row0_r;
  logic [DIST_W-1:0] last_r;
  logic [CHAR_W-1:0] ch_r;
  logic              wave0_vld_r;
  logic [DIST_W-1:0] wave0_left_r;
  logic [DIST_W-1:0] wave0_diag_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_status_r;

  logic              accept;
  logic              full;
  logic              append_ok;
  logic              row_init;
  logic [LEN_W-1:0]  len_inc;
  logic [DIST_W-1:0] row0_nxt;

  wave_t             waves [0:MAX_LEN];
  logic [MAX_LEN:0]  wave_vlds;

  assign in_ready  = !busy_r && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign full      = (len_r == LEN_MAX);
  assign len_inc   = len_r + LEN_W'(1);
  assign append_ok = accept && (in_op == OP_APPEND) && !full;
  assign row_init  = accept && ((in_op == OP_START) || (append_ok && fed_r));
  assign row0_nxt  = sat_inc(row0_r);

  assign waves[0].valid = wave0_vld_r;
  assign waves[0].left  = wave0_left_r;
  assign waves[0].diag  = wave0_diag_r;

  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    edr_cell #(
      .CELL_IDX (k),
      .LEN_W    (LEN_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .init     (row_init),
      .wr_en    (append_ok),
      .wr_idx   (len_inc),
      .wr_ch    (in_ch),
      .ch       (ch_r),
      .len      (len_r),
      .wave_in  (waves[k-1]),
      .wave_out (waves[k])
    );
  end

  for (genvar k = 0; k <= MAX_LEN; k++) begin : g_vld
    assign wave_vlds[k] = waves[k].valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fed_r       <= 1'b0;
      len_r       <= '0;
      row0_r      <= '0;
      last_r      <= '0;
      wave0_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wave0_vld_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (waves[MAX_LEN].valid) begin
        busy_r      <= 1'b0;
        last_r      <= waves[MAX_LEN].left;
        out_valid_r <= 1'b1;
      end
      if (accept) begin
        case (in_op)
          OP_START: begin
            len_r       <= '0;
            fed_r       <= 1'b0;
            row0_r      <= '0;
            last_r      <= '0;
            out_valid_r <= 1'b1;
          end
          OP_APPEND: begin
            if (!full) begin
              len_r  <= len_inc;
              last_r <= DIST_W'(len_inc);
              if (fed_r) begin
                fed_r  <= 1'b0;
                row0_r <= '0;
              end
            end
            out_valid_r <= 1'b1;
          end
          OP_FEED: begin
            fed_r       <= 1'b1;
            row0_r      <= row0_nxt;
            wave0_vld_r <= 1'b1;
            busy_r      <= 1'b1;
          end
          default: begin
            out_valid_r <= 1'b1;
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (waves[MAX_LEN].valid) begin
      out_dist_r   <= waves[MAX_LEN].left;
      out_status_r <= ST_OK;
    end
    if (accept) begin
      case (in_op)
        OP_START: begin
          out_dist_r   <= '0;
          out_status_r <= ST_OK;
        end
        OP_APPEND: begin
          out_dist_r   <= full ? last_r : DIST_W'(len_inc);
          out_status_r <= full ? ST_FULL : ST_OK;
        end
        OP_FEED: begin
          ch_r         <= in_ch;
          wave0_left_r <= row0_nxt;
          wave0_diag_r <= row0_r;
        end
        default: begin
          out_dist_r   <= last_r;
          out_status_r <= ST_OK;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_status   = out_status_r;

  // Only one wavefront may be in the chain at a time.
  a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wave_vlds))
    else $error("more than one wavefront in the cell chain");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    waves[MAX_LEN].valid |-> busy_r)
    else $error("wavefront reached the chain end while not busy");

  a_feed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_FEED)) |=> (busy_r && wave0_vld_r))
    else $error("feed word did not launch a wavefront");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("reference length beyond capacity");

endmodule

`default_nettype wire
